// ----- src/nem_pkg.sv -----
// Shared types and constants of the nearest event matcher.
package nem_pkg;

  localparam int unsigned SumW = 60;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef enum logic [1:0] {
    KIND_REF  = 2'd0,
    KIND_CAND = 2'd1,
    KIND_EMIT = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_COUNT = 2'd0,
    CFG_PTW   = 2'd1,
    CFG_ETAW  = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [15:0] particle_id;
    logic [15:0] pt;
    logic [15:0] eta;
    logic [7:0]  event_class;
  } in_word_t;

  typedef struct packed {
    logic [SumW-1:0] nearest_distance_sq;
    logic [7:0]      nearest_class;
    logic            found_match;
  } out_word_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pt;
    logic [15:0] eta;
  } particle_t;

  // 0 other, 1 electron, 2 muon
  function automatic logic [1:0] lepton_kind(input logic [15:0] id);
    logic [15:0] a;
    begin
      a = id[15] ? (~id + 16'd1) : id;
      if (a == 16'd11) lepton_kind = 2'd1;
      else if (a == 16'd13) lepton_kind = 2'd2;
      else lepton_kind = 2'd0;
    end
  endfunction

endpackage

// ----- src/nem_if.sv -----
// Valid/ready channel interfaces of the nearest event matcher.
interface nem_in_if;
  logic             valid;
  logic             ready;
  nem_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nem_out_if;
  logic              valid;
  logic              ready;
  nem_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/nearest_event_matcher_unit.sv -----
// Nearest event matcher: particle stores in memories, sequential greedy matching.
// Reference and plain candidate words are accepted while idle. A completing candidate word
// is accepted, then the leptons are tallied over the n slots (n = particle count), then
// the pairs, up to n*n, each pass S_RCAND, S_MUL, S_RREF and S_ACC; S_DONE updates the best.
// An emit word is accepted while idle; a further emit waits until its result has been taken.
// Reset (synchronous, rst_n low) loads register defaults and clears the best result.
module nearest_event_matcher_unit #(
  parameter int unsigned MAX_PARTICLES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  nem_in_if.sink      in_ch,
  nem_out_if.source   out_ch
);
  localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned NMAX = (MAX_PARTICLES < 8) ? MAX_PARTICLES : 8;
  localparam int unsigned CW = 4;
  localparam int unsigned SumW = nem_pkg::SumW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CNT   = 7'b0000010,
    S_RREF  = 7'b0000100,
    S_RCAND = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_ACC   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0]  count_r;
  logic [15:0] ptw_r, etaw_r;

  nem_pkg::particle_t ref_mem [MAX_PARTICLES];
  nem_pkg::particle_t cand_mem [MAX_PARTICLES];
  nem_pkg::particle_t ref_q, cand_q;
  logic [AW-1:0] ref_ra, cand_ra;

  logic [CW-1:0] r_r, c_r, n_r;
  logic [7:0]    cls_r;
  logic [7:0]    taken_r;
  logic [7:0]    ne_r, nm_r; // signed differences of lepton counts, ref minus cand
  logic          found_r;
  logic [AW-1:0] pick_r;
  logic [49:0]   bestc_r;
  logic [SumW-1:0] sum_r;

  logic [SumW-1:0] best_sum_r;
  logic [7:0]      best_class_r;
  logic            have_best_r;

  logic [16:0] dp_r, de_r;
  logic [16:0] dp_neg, de_neg;
  logic [15:0] dp_abs, de_abs;
  logic [33:0] dp2_r, de2_r;
  logic [49:0] cost;
  logic        pair_ok_r;

  logic            out_valid_r;
  nem_pkg::out_word_t out_data_r;

  logic [3:0] n_used;
  always_comb begin
    n_used = (count_r == 4'd0) ? 4'd1 : count_r;
    if (n_used > 4'(NMAX)) n_used = 4'(NMAX);
  end

  nem_pkg::in_word_t iw;
  assign iw = in_ch.data;
  logic acc;
  assign in_ch.ready = (state_r == S_IDLE) && !(out_valid_r && iw.kind == nem_pkg::KIND_EMIT);
  assign acc = in_ch.valid && in_ch.ready;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 4'd6;
      ptw_r   <= 16'd41;
      etaw_r  <= 16'd1;
    end else if (cfg_we) begin
      unique case (nem_pkg::cfg_idx_t'(cfg_index))
        nem_pkg::CFG_COUNT: count_r <= cfg_wdata[3:0];
        nem_pkg::CFG_PTW:   ptw_r <= cfg_wdata;
        nem_pkg::CFG_ETAW:  etaw_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // memories: write on accepted words, registered read
  logic wr_ok;
  assign wr_ok = 5'(iw.slot) < 5'(MAX_PARTICLES);
  always_ff @(posedge clk) begin
    if (acc && wr_ok && iw.kind == nem_pkg::KIND_REF)
      ref_mem[AW'(iw.slot)] <= '{iw.particle_id, iw.pt, iw.eta};
    if (acc && wr_ok && iw.kind == nem_pkg::KIND_CAND)
      cand_mem[AW'(iw.slot)] <= '{iw.particle_id, iw.pt, iw.eta};
    ref_q  <= ref_mem[ref_ra];
    cand_q <= cand_mem[cand_ra];
  end

  logic last_c;
  assign last_c = (c_r == n_r - 4'd1);

  always_comb begin
    ref_ra  = AW'(r_r);
    cand_ra = AW'(c_r);
    if (state_r == S_CNT) cand_ra = AW'(r_r);
  end

  // square magnitudes only, so fold the sign off first
  always_comb begin
    dp_neg = ~dp_r + 17'd1;
    de_neg = ~de_r + 17'd1;
    dp_abs = dp_r[16] ? dp_neg[15:0] : dp_r[15:0];
    de_abs = de_r[16] ? de_neg[15:0] : de_r[15:0];
  end

  assign cost = 50'(dp2_r) * 50'(ptw_r) + 50'(de2_r) * 50'(etaw_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc && iw.kind == nem_pkg::KIND_CAND &&
                  {1'b0, iw.slot} == n_used - 4'd1) state_nxt = S_CNT;
      S_CNT:  state_nxt = S_CNT;
      S_RREF, S_RCAND, S_MUL, S_ACC: state_nxt = state_r;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer
  logic [1:0] kr, kc;
  assign kr = nem_pkg::lepton_kind(ref_q.id);
  assign kc = nem_pkg::lepton_kind(cand_q.id);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      best_sum_r   <= nem_pkg::SumMax;
      best_class_r <= 8'd0;
      have_best_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc && iw.kind == nem_pkg::KIND_EMIT) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= '{best_sum_r, best_class_r, have_best_r};
            best_sum_r   <= nem_pkg::SumMax;
            best_class_r <= 8'd0;
            have_best_r  <= 1'b0;
          end
          if (state_nxt == S_CNT) begin
            cls_r <= iw.event_class;
            n_r   <= n_used;
            r_r   <= '0;
            c_r   <= '0;
            ne_r  <= '0;
            nm_r  <= '0;
            state_r <= S_CNT;
          end
        end
        // walk slots, reading ref and cand at the same index; tally the data in the cycle after its read
        S_CNT: begin
          if (c_r != '0) begin
            ne_r <= ne_r + 8'(kr == 2'd1) - 8'(kc == 2'd1);
            nm_r <= nm_r + 8'(kr == 2'd2) - 8'(kc == 2'd2);
          end
          if (c_r == n_r) begin
            if (ne_r + 8'(kr == 2'd1) - 8'(kc == 2'd1) != 8'd0 ||
                nm_r + 8'(kr == 2'd2) - 8'(kc == 2'd2) != 8'd0) begin
              state_r <= S_IDLE;
            end else begin
              r_r <= '0; c_r <= '0; taken_r <= '0; sum_r <= '0; found_r <= 1'b0;
              state_r <= S_RCAND;
            end
          end else begin
            r_r <= r_r + 4'd1;
            c_r <= c_r + 4'd1;
          end
        end
        // addresses r_r, c_r were presented; data arrives next cycle
        S_RCAND: state_r <= S_MUL;
        S_MUL: begin
          dp_r <= {1'b0, ref_q.pt} - {1'b0, cand_q.pt};
          de_r <= {ref_q.eta[15], ref_q.eta} - {cand_q.eta[15], cand_q.eta};
          pair_ok_r <= !taken_r[3'(c_r)] && (ref_q.id == cand_q.id);
          state_r <= S_RREF;
        end
        S_RREF: begin
          dp2_r <= {2'b00, 32'(dp_abs) * 32'(dp_abs)};
          de2_r <= {2'b00, 32'(de_abs) * 32'(de_abs)};
          state_r <= S_ACC;
        end
        S_ACC: begin
          logic fnd;
          logic [AW-1:0] pk;
          logic [49:0] bc;
          fnd = found_r; pk = pick_r; bc = bestc_r;
          if (pair_ok_r && (!found_r || cost < bestc_r)) begin
            fnd = 1'b1; pk = AW'(c_r); bc = cost;
          end
          if (last_c) begin
            if (!fnd) begin
              state_r <= S_IDLE;
            end else begin
              taken_r[3'(pk)] <= 1'b1;
              sum_r <= ({1'b0, sum_r} + (SumW+1)'(bc) > (SumW+1)'(nem_pkg::SumMax))
                       ? nem_pkg::SumMax : SumW'({1'b0, sum_r} + (SumW+1)'(bc));
              found_r <= 1'b0;
              c_r <= '0;
              if (r_r == n_r - 4'd1) begin
                state_r <= S_DONE;
              end else begin
                r_r <= r_r + 4'd1;
                state_r <= S_RCAND;
              end
            end
          end else begin
            found_r <= fnd; pick_r <= pk; bestc_r <= bc;
            c_r <= c_r + 4'd1;
            state_r <= S_RCAND;
          end
        end
        S_DONE: begin
          if (sum_r < best_sum_r) begin
            best_sum_r   <= sum_r;
            best_class_r <= cls_r;
            have_best_r  <= 1'b1;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
endmodule

// ----- verif/nearest_event_matcher_unit_tb.sv -----
// Testbench of the nearest event matcher: random and directed words, scoreboard check.
module nearest_event_matcher_unit_tb;

  typedef struct {
    logic [nem_pkg::SumW-1:0] distance;
    logic [7:0]               cls;
    logic                     found;
  } nearest_t;

  class nearest_scoreboard;
    logic [3:0]  count_reg;
    logic [15:0] ptw_reg;
    logic [15:0] etaw_reg;
    logic [15:0] ref_id [8];
    logic [15:0] ref_pt [8];
    logic [15:0] ref_eta [8];
    logic [15:0] cand_id [8];
    logic [15:0] cand_pt [8];
    logic [15:0] cand_eta [8];
    logic [nem_pkg::SumW-1:0] best_sum;
    logic [7:0]      best_cls;
    logic            have_best;
    nearest_t        expected_q[$];
    int              errors;

    function new();
      count_reg = 4'd6;
      ptw_reg   = 16'd41;
      etaw_reg  = 16'd1;
      best_sum  = nem_pkg::SumMax;
      best_cls  = 8'd0;
      have_best = 1'b0;
      errors    = 0;
      for (int i = 0; i < 8; i++) begin
        ref_id[i] = '0; ref_pt[i] = '0; ref_eta[i] = '0;
        cand_id[i] = '0; cand_pt[i] = '0; cand_eta[i] = '0;
      end
    endfunction

    function void write_reg(nem_pkg::cfg_idx_t idx, logic [15:0] val);
      case (idx)
        nem_pkg::CFG_COUNT: count_reg = val[3:0];
        nem_pkg::CFG_PTW:   ptw_reg = val;
        nem_pkg::CFG_ETAW:  etaw_reg = val;
        default: ;
      endcase
    endfunction

    function int active_slots();
      int n;
      n = count_reg;
      if (n == 0) n = 1;
      if (n > 8) n = 8;
      return n;
    endfunction

    function int lepton(logic [15:0] id);
      int v;
      v = $signed(id);
      if (v < 0) v = -v;
      if (v == 11) return 1;
      if (v == 13) return 2;
      return 0;
    endfunction

    function longint unsigned pair_cost(int r, int c);
      longint dp, de;
      dp = longint'({48'd0, ref_pt[r]}) - longint'({48'd0, cand_pt[c]});
      de = longint'($signed(ref_eta[r])) - longint'($signed(cand_eta[c]));
      return longint'(dp * dp) * longint'({48'd0, ptw_reg})
           + longint'(de * de) * longint'({48'd0, etaw_reg});
    endfunction

    function void score_event(logic [7:0] cls);
      int n, re, rm, ce, cm, pick;
      logic [7:0] taken;
      longint unsigned sum, bestc, d, smax;
      bit found;
      n = active_slots();
      re = 0; rm = 0; ce = 0; cm = 0;
      smax = {4'd0, nem_pkg::SumMax};
      for (int r = 0; r < n; r++) begin
        if (lepton(ref_id[r]) == 1) re++;
        if (lepton(ref_id[r]) == 2) rm++;
        if (lepton(cand_id[r]) == 1) ce++;
        if (lepton(cand_id[r]) == 2) cm++;
      end
      if (re != ce || rm != cm) return;
      taken = '0;
      sum = 0;
      for (int r = 0; r < n; r++) begin
        found = 0; pick = 0; bestc = 0;
        for (int c = 0; c < n; c++) begin
          if (taken[c] || ref_id[r] != cand_id[c]) continue;
          d = pair_cost(r, c);
          if (!found || d < bestc) begin
            found = 1; bestc = d; pick = c;
          end
        end
        // drop the event when a particle has no partner
        if (!found) return;
        taken[pick] = 1'b1;
        if (bestc > smax - sum) sum = smax;
        else sum = sum + bestc;
      end
      if (sum < {4'd0, best_sum}) begin
        best_sum = sum[nem_pkg::SumW-1:0];
        best_cls = cls;
        have_best = 1'b1;
      end
    endfunction

    function void note_input(nem_pkg::in_word_t w);
      nearest_t e;
      case (nem_pkg::kind_t'(w.kind))
        nem_pkg::KIND_REF: begin
          ref_id[w.slot] = w.particle_id; ref_pt[w.slot] = w.pt; ref_eta[w.slot] = w.eta;
        end
        nem_pkg::KIND_CAND: begin
          cand_id[w.slot] = w.particle_id; cand_pt[w.slot] = w.pt;
          cand_eta[w.slot] = w.eta;
          if (int'(w.slot) == active_slots() - 1) score_event(w.event_class);
        end
        nem_pkg::KIND_EMIT: begin
          e.distance = best_sum; e.cls = best_cls; e.found = have_best;
          expected_q = {expected_q, e};
          best_sum = nem_pkg::SumMax; best_cls = 8'd0; have_best = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(nem_pkg::out_word_t w);
      nearest_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, w);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (w.nearest_distance_sq !== e.distance) begin
        $display("%0t: distance expected %h actual %h", $time, e.distance,
                 w.nearest_distance_sq);
        errors++;
      end
      if (w.nearest_class !== e.cls) begin
        $display("%0t: class expected %h actual %h", $time, e.cls, w.nearest_class);
        errors++;
      end
      if (w.found_match !== e.found) begin
        $display("%0t: found expected %b actual %b", $time, e.found, w.found_match);
        errors++;
      end
    endfunction
  endclass

  localparam int SettleCycles = 150;
  localparam int StallLimit = 5000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  nem_in_if  in_ch();
  nem_out_if out_ch();

  nearest_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  hold_req = 0;
  bit  no_gaps = 0;
  int  ref_n = 8;
  logic [15:0] cur_id [8];
  logic [15:0] cur_pt [8];
  logic [15:0] cur_eta [8];

  nearest_event_matcher_unit DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // accepted words on both channels, plus the watchdog
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    if (rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: mostly short stalls, a few long ones, one long hold-off on request
  initial begin
    int r;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end else begin
          out_ch.ready <= no_gaps || (r < 75);
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_word(logic [1:0] kind, logic [2:0] slot, logic [15:0] id,
                           logic [15:0] pt, logic [15:0] eta, logic [7:0] cls);
    nem_pkg::in_word_t w;
    int gap;
    w.kind = kind; w.slot = slot; w.particle_id = id; w.pt = pt; w.eta = eta;
    w.event_class = cls;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(nem_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  function logic [15:0] pick_id();
    case ($urandom_range(0, 9))
      0, 1: return 16'd11;
      2:    return -16'sd11;
      3, 4: return 16'd13;
      5:    return -16'sd13;
      6:    return 16'd22;
      7:    return 16'd211;
      8:    return -16'sd211;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_ref_event(int n);
    for (int s = 0; s < n; s++) begin
      cur_id[s] = pick_id();
      cur_pt[s] = 16'($urandom_range(0, 65535));
      cur_eta[s] = 16'($urandom_range(0, 65535));
      send_word(nem_pkg::KIND_REF, 3'(s), cur_id[s], cur_pt[s], cur_eta[s],
                8'($urandom_range(0, 255)));
    end
    ref_n = n;
  endtask

  // permuted reference ids with nearby kinematics, sometimes fully random
  task automatic send_cand_event(int n);
    logic [15:0] ids [8];
    logic [15:0] t;
    int j, mode;
    mode = $urandom_range(0, 9);
    for (int s = 0; s < 8; s++) ids[s] = cur_id[s];
    for (int s = n - 1; s > 0; s--) begin
      j = $urandom_range(0, s);
      t = ids[s]; ids[s] = ids[j]; ids[j] = t;
    end
    for (int s = 0; s < n; s++) begin
      if (mode == 0 || n > ref_n) ids[s] = pick_id();
      if (mode < 2)
        send_word(nem_pkg::KIND_CAND, 3'(s), ids[s], 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      else
        send_word(nem_pkg::KIND_CAND, 3'(s), ids[s],
                  16'(cur_pt[s] + $urandom_range(0, 255) - 128),
                  16'(cur_eta[s] + $urandom_range(0, 255) - 128),
                  8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_phase(int items);
    int sent, n, r;
    sent = 0;
    n = sb.active_slots();
    while (sent < items) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_ref_event(n); sent += n;
      end else if (r < 70) begin
        send_cand_event(n); sent += n;
      end else if (r < 88) begin
        send_word(nem_pkg::KIND_EMIT, 3'($urandom_range(0, 7)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        sent++;
      end else if (r < 93) begin
        send_word(nem_pkg::KIND_NONE, 3'($urandom_range(0, 7)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end else begin
        // broken event: a lone candidate at any slot
        send_word(nem_pkg::KIND_CAND, 3'($urandom_range(0, 7)), pick_id(),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)));
        sent++;
      end
    end
    send_word(nem_pkg::KIND_EMIT, 3'd0, 16'd0, 16'd0, 16'd0, 8'd0);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = nem_pkg::CFG_COUNT;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every slot of both stores; the candidate at slot 5 completes the first scored event
    for (int s = 0; s < 8; s++) begin
      cur_id[s] = (s % 2) ? 16'd11 : 16'd13;
      cur_pt[s] = (s == 0) ? 16'hffff : 16'(100 * s);
      cur_eta[s] = (s == 1) ? 16'h8000 : (s == 2) ? 16'h7fff : 16'(50 * s);
      send_word(nem_pkg::KIND_REF, 3'(s), cur_id[s], cur_pt[s], cur_eta[s], 8'd0);
    end
    for (int s = 0; s < 8; s++)
      send_word(nem_pkg::KIND_CAND, 3'(s), cur_id[7 - s],
                (s == 3) ? 16'd0 : cur_pt[s] + 16'd3,
                (s == 4) ? 16'h7fff : cur_eta[s], 8'hff);
    send_word(nem_pkg::KIND_EMIT, 3'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    send_word(nem_pkg::KIND_EMIT, 3'd7, 16'hffff, 16'hffff, 16'hffff, 8'hff);
    send_word(nem_pkg::KIND_NONE, 3'd5, 16'd11, 16'd1, 16'd1, 8'd1);
    // electron at slot 0 replaced by muon, muon at slot 5 by electron: counts still agree
    send_word(nem_pkg::KIND_CAND, 3'd0, 16'd13, 16'd0, 16'd0, 8'd3);
    send_word(nem_pkg::KIND_CAND, 3'd5, 16'd11, 16'd0, 16'd0, 8'd3);
    // a sign flip at slot 0 and a muon at slot 5 leave a lepton count mismatch
    send_word(nem_pkg::KIND_CAND, 3'd0, -16'sd13, 16'd0, 16'd0, 8'd4);
    send_word(nem_pkg::KIND_CAND, 3'd5, cur_id[2], 16'd0, 16'd0, 8'd4);
    send_word(nem_pkg::KIND_EMIT, 3'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    drain();

    write_reg(nem_pkg::CFG_COUNT, 16'd1);
    write_reg(nem_pkg::CFG_PTW, 16'd0);
    write_reg(nem_pkg::CFG_ETAW, 16'd0);
    random_phase(170);
    drain();

    write_reg(nem_pkg::CFG_COUNT, 16'd8);
    write_reg(nem_pkg::CFG_PTW, 16'hffff);
    write_reg(nem_pkg::CFG_ETAW, 16'hffff);
    hold_req = 1;
    random_phase(170);
    drain();

    write_reg(nem_pkg::CFG_COUNT, 16'd0);
    write_reg(nem_pkg::CFG_PTW, 16'd1);
    no_gaps = 1;
    random_phase(150);
    no_gaps = 0;
    drain();

    write_reg(nem_pkg::CFG_COUNT, 16'd9);
    write_reg(nem_pkg::CFG_PTW, 16'd0);
    write_reg(nem_pkg::CFG_ETAW, 16'hffff);
    random_phase(170);
    drain();

    write_reg(nem_pkg::CFG_COUNT, 16'd15);
    write_reg(nem_pkg::CFG_PTW, 16'd7);
    write_reg(nem_pkg::CFG_ETAW, 16'd3);
    random_phase(170);
    drain();

    write_reg(nem_pkg::CFG_COUNT, 16'd3);
    write_reg(nem_pkg::CFG_PTW, 16'($urandom_range(0, 65535)));
    write_reg(nem_pkg::CFG_ETAW, 16'($urandom_range(0, 65535)));
    random_phase(170);
    drain();

    write_reg(nem_pkg::CFG_COUNT, 16'd6);
    write_reg(nem_pkg::CFG_PTW, 16'd41);
    write_reg(nem_pkg::CFG_ETAW, 16'd1);
    random_phase(170);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
